@@ sv/mcms_pkg.sv @@
// shared types and constants for the mesh composition model scanner
// no dependencies; used by every module of the block

package mcms_pkg;

	// header bytes skipped at the start of page 0
	localparam logic [15:0] HEADER_BYTES = 16'd10;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ONOFF_SERVER  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONOFF_CLIENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_CMPNY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_SERVER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_CLIENT = 3'd4;

	// register reset values
	localparam logic [15:0] RST_ONOFF_SERVER  = 16'd4096;
	localparam logic [15:0] RST_ONOFF_CLIENT  = 16'd4097;
	localparam logic [15:0] RST_VENDOR_CMPNY  = 16'd741;
	localparam logic [15:0] RST_VENDOR_SERVER = 16'd0;
	localparam logic [15:0] RST_VENDOR_CLIENT = 16'd1;

	// configured ids, from the register file to the parser
	typedef struct packed {
		logic [15:0] onoff_server_id;
		logic [15:0] onoff_client_id;
		logic [15:0] vendor_company_id;
		logic [15:0] vendor_server_id;
		logic [15:0] vendor_client_id;
	} cfg_t;

	// one input transfer
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// one result transfer
	typedef struct packed {
		logic valid_data;
		logic has_onoff_server;
		logic has_onoff_client;
		logic has_vendor_server;
		logic has_vendor_client;
	} out_item_t;

endpackage

@@ sv/mcms_cfg_regs.sv @@
// configuration register file of the mesh composition model scanner
// depends on mcms_pkg for register indexes, reset values and cfg_t

module mcms_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mcms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output mcms_pkg::cfg_t                     cfg
);

	mcms_pkg::cfg_t cfg_q;

	// register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.onoff_server_id   <= mcms_pkg::RST_ONOFF_SERVER;
			cfg_q.onoff_client_id   <= mcms_pkg::RST_ONOFF_CLIENT;
			cfg_q.vendor_company_id <= mcms_pkg::RST_VENDOR_CMPNY;
			cfg_q.vendor_server_id  <= mcms_pkg::RST_VENDOR_SERVER;
			cfg_q.vendor_client_id  <= mcms_pkg::RST_VENDOR_CLIENT;
		end else if (cfg_we) begin
			case (cfg_index)
				mcms_pkg::CFG_ONOFF_SERVER:  cfg_q.onoff_server_id   <= cfg_wdata;
				mcms_pkg::CFG_ONOFF_CLIENT:  cfg_q.onoff_client_id   <= cfg_wdata;
				mcms_pkg::CFG_VENDOR_CMPNY:  cfg_q.vendor_company_id <= cfg_wdata;
				mcms_pkg::CFG_VENDOR_SERVER: cfg_q.vendor_server_id  <= cfg_wdata;
				mcms_pkg::CFG_VENDOR_CLIENT: cfg_q.vendor_client_id  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/mcms_parser.sv @@
// byte-wise composition data parser: phase state, model matching, flags
// depends on mcms_pkg for in_item_t, out_item_t, cfg_t and HEADER_BYTES

module mcms_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  mcms_pkg::in_item_t   item,
	input  mcms_pkg::cfg_t       cfg,
	output mcms_pkg::out_item_t  result
);

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_LOC       = 3'd1,
		PH_SIG_COUNT = 3'd2,
		PH_VND_COUNT = 3'd3,
		PH_SIG_MODEL = 3'd4,
		PH_VND_MODEL = 3'd5
	} phase_t;

	localparam logic [15:0] HEADER_LAST = mcms_pkg::HEADER_BYTES - 16'd1;

	phase_t      phase_q,   phase_d;
	logic [15:0] count_q,   count_d;
	logic [7:0]  sig_q,     sig_d;
	logic [7:0]  vnd_q,     vnd_d;
	logic [1:0]  bie_q,     bie_d;
	logic [23:0] held_q,    held_d;
	logic [3:0]  flags_q,   flags_d;

	logic [7:0]  b;
	logic [15:0] sig_id;
	logic [15:0] cid;
	logic [15:0] mid;
	logic [7:0]  sig_dec;
	logic [7:0]  vnd_dec;
	logic        valid;

	assign b       = item.data_byte;
	assign sig_id  = {b, held_q[7:0]};
	assign cid     = held_q[15:0];
	assign mid     = {b, held_q[23:16]};
	assign sig_dec = sig_q - 8'd1;
	assign vnd_dec = vnd_q - 8'd1;

	// next state for one byte
	always_comb begin
		phase_d = phase_q;
		sig_d   = sig_q;
		vnd_d   = vnd_q;
		bie_d   = bie_q;
		held_d  = held_q;
		flags_d = flags_q;
		count_d = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;

		case (phase_q)
			PH_HEADER: begin
				if (count_q >= HEADER_LAST) begin
					phase_d = PH_LOC;
					bie_d   = 2'd0;
				end
			end
			PH_SIG_COUNT: begin
				sig_d   = b;
				phase_d = PH_VND_COUNT;
			end
			PH_VND_COUNT: begin
				vnd_d  = b;
				bie_d  = 2'd0;
				held_d = '0;
				if (sig_q != 8'd0)   phase_d = PH_SIG_MODEL;
				else if (b != 8'd0)  phase_d = PH_VND_MODEL;
				else                 phase_d = PH_LOC;
			end
			PH_SIG_MODEL: begin
				if (bie_q == 2'd0) begin
					held_d = {16'd0, b};
					bie_d  = 2'd1;
				end else begin
					if (sig_id == cfg.onoff_server_id)      flags_d[0] = 1'b1;
					else if (sig_id == cfg.onoff_client_id) flags_d[1] = 1'b1;
					sig_d  = sig_dec;
					bie_d  = 2'd0;
					held_d = '0;
					if (sig_dec != 8'd0)     phase_d = PH_SIG_MODEL;
					else if (vnd_q != 8'd0)  phase_d = PH_VND_MODEL;
					else                     phase_d = PH_LOC;
				end
			end
			PH_VND_MODEL: begin
				if (bie_q != 2'd3) begin
					case (bie_q)
						2'd0:    held_d[7:0]   = held_q[7:0]   | b;
						2'd1:    held_d[15:8]  = held_q[15:8]  | b;
						default: held_d[23:16] = held_q[23:16] | b;
					endcase
					bie_d = bie_q + 2'd1;
				end else begin
					if (cid == cfg.vendor_company_id && mid == cfg.vendor_server_id)
						flags_d[2] = 1'b1;
					else if (cid == cfg.vendor_company_id && mid == cfg.vendor_client_id)
						flags_d[3] = 1'b1;
					vnd_d  = vnd_dec;
					bie_d  = 2'd0;
					held_d = '0;
					if (sig_q != 8'd0)        phase_d = PH_SIG_MODEL;
					else if (vnd_dec != 8'd0) phase_d = PH_VND_MODEL;
					else                      phase_d = PH_LOC;
				end
			end
			// location bytes
			default: begin
				if (bie_q == 2'd0) begin
					phase_d = PH_LOC;
					bie_d   = 2'd1;
				end else begin
					phase_d = PH_SIG_COUNT;
					bie_d   = 2'd0;
				end
			end
		endcase
	end

	// report on the final byte
	assign valid                    = count_d >= mcms_pkg::HEADER_BYTES;
	assign result.valid_data        = valid;
	assign result.has_onoff_server  = valid & flags_d[0];
	assign result.has_onoff_client  = valid & flags_d[1];
	assign result.has_vendor_server = valid & flags_d[2];
	assign result.has_vendor_client = valid & flags_d[3];

	// parse state; cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= '0;
			sig_q   <= '0;
			vnd_q   <= '0;
			bie_q   <= '0;
			held_q  <= '0;
			flags_q <= '0;
		end else if (take) begin
			if (item.last_byte) begin
				phase_q <= PH_HEADER;
				count_q <= '0;
				sig_q   <= '0;
				vnd_q   <= '0;
				bie_q   <= '0;
				held_q  <= '0;
				flags_q <= '0;
			end else begin
				phase_q <= phase_d;
				count_q <= count_d;
				sig_q   <= sig_d;
				vnd_q   <= vnd_d;
				bie_q   <= bie_d;
				held_q  <= held_d;
				flags_q <= flags_d;
			end
		end
	end

endmodule

@@ sv/mesh_composition_model_scanner_unit.sv @@
// top level of the mesh composition model scanner
// depends on mcms_pkg, mcms_cfg_regs and mcms_parser
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------
//  in       | input     | in_valid / in_ready  | in_data  (in_item_t)
//  out      | output    | out_valid / out_ready| out_data (out_item_t)
//  cfg      | input     | cfg_we               | cfg_index, cfg_wdata
//
// one byte is taken per cycle while in_ready is high; parse state updates
// at the transfer and the result appears in the output register next cycle
// in_ready stays high while the output register is empty or being drained
// a pending result that is not drained holds off every input transfer,
// since any byte may be last
// reset clears parse state and out_valid and loads register defaults

module mesh_composition_model_scanner_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mcms_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mcms_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [mcms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	mcms_pkg::cfg_t       cfg;
	mcms_pkg::out_item_t  result;
	mcms_pkg::out_item_t  out_data_q;
	logic                 out_valid_q;
	logic                 take;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	mcms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mcms_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (in_data),
		.cfg    (cfg),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && in_data.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_data.last_byte) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ dv/mesh_composition_model_scanner_unit_test.sv @@
// self-checking testbench for mesh_composition_model_scanner_unit
// depends on mcms_pkg and the scanner rtl; directed rows then random frames
`timescale 1ns / 1ps

module mesh_composition_model_scanner_unit_test;

	localparam int    SETTINGS_PER_MODE = 4;
	localparam int    ITEMS_PER_SETTING = 90;
	localparam int    RESULTS_PER_SETTING = 4;
	localparam int    HOLD_CYCLES = 200;
	localparam int    SETTLE_CYCLES = 6;
	localparam int    N_DIRECTED = 27;

	// parse phases of the scan predictor
	typedef enum logic [2:0] {
		SCAN_HEADER, SCAN_LOCATION, SCAN_SIG_COUNT, SCAN_VND_COUNT,
		SCAN_SIG_ID, SCAN_VND_ENTRY
	} scan_phase_t;

	// one directed row; want is used only where fixed is set
	typedef struct packed {
		logic [7:0]          data_byte;
		logic                last_byte;
		logic                fixed;
		mcms_pkg::out_item_t want;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	mcms_pkg::in_item_t              in_data;
	logic                            out_valid;
	logic                            out_ready;
	mcms_pkg::out_item_t             out_data;
	logic                            cfg_we;
	logic [mcms_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mcms_pkg::CFG_DATA_W-1:0] cfg_wdata;

	mesh_composition_model_scanner_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor copy of registers and parse state
	mcms_pkg::cfg_t model_cfg;
	logic [15:0] scan_count;
	scan_phase_t scan_phase;
	logic [7:0]  sig_left;
	logic [7:0]  vnd_left;
	logic [1:0]  entry_pos;
	logic [23:0] entry_held;
	logic        seen_srv, seen_cli, seen_vsrv, seen_vcli;

	mcms_pkg::out_item_t expected_flags_q[$];
	logic [7:0]  frame_bytes[$];
	int          mismatch_count = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	bit          hold_req = 1'b0;

	// directed rows: short buffer, header extremes, empty element, model flags
	dir_row_t dir_rows [N_DIRECTED] = '{
		'{8'hFF, 1'b1, 1'b1, 5'b00000},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'hFF, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'hFF, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'hFF, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'hFF, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'hFF, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'hFF, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'h00, 1'b0, 1'b0, 5'b0},
		'{8'h7F, 1'b0, 1'b0, 5'b0}, '{8'h80, 1'b0, 1'b0, 5'b0},
		'{8'h02, 1'b0, 1'b0, 5'b0}, '{8'h01, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'h10, 1'b0, 1'b0, 5'b0},
		'{8'h01, 1'b0, 1'b0, 5'b0}, '{8'h10, 1'b0, 1'b0, 5'b0},
		'{8'hE5, 1'b0, 1'b0, 5'b0}, '{8'h02, 1'b0, 1'b0, 5'b0},
		'{8'h00, 1'b0, 1'b0, 5'b0}, '{8'h00, 1'b1, 1'b0, 5'b0}
	};

	task automatic scan_clear();
		scan_count = '0;
		scan_phase = SCAN_HEADER;
		sig_left   = '0;
		vnd_left   = '0;
		entry_pos  = '0;
		entry_held = '0;
		{seen_srv, seen_cli, seen_vsrv, seen_vcli} = '0;
	endtask

	// phase after the counts or after a finished model
	task automatic pick_model_phase();
		entry_pos  = '0;
		entry_held = '0;
		if (sig_left != 0) scan_phase = SCAN_SIG_ID;
		else if (vnd_left != 0) scan_phase = SCAN_VND_ENTRY;
		else scan_phase = SCAN_LOCATION;
	endtask

	// advance the predictor by one byte; a marked byte yields the flags
	task automatic scan_byte(input logic [7:0] b, input logic lst,
			output bit got, output mcms_pkg::out_item_t res);
		logic [15:0] id;
		logic [15:0] mid;
		logic        ok;
		case (scan_phase)
			SCAN_HEADER: begin
				if (scan_count >= mcms_pkg::HEADER_BYTES - 16'd1) begin
					scan_phase = SCAN_LOCATION;
					entry_pos  = '0;
				end
			end
			SCAN_SIG_COUNT: begin
				sig_left   = b;
				scan_phase = SCAN_VND_COUNT;
			end
			SCAN_VND_COUNT: begin
				vnd_left = b;
				pick_model_phase();
			end
			SCAN_SIG_ID: begin
				if (entry_pos == 0) begin
					entry_held = {16'h0000, b};
					entry_pos  = 2'd1;
				end else begin
					id = {b, entry_held[7:0]};
					if (id == model_cfg.onoff_server_id) seen_srv = 1'b1;
					else if (id == model_cfg.onoff_client_id) seen_cli = 1'b1;
					sig_left = sig_left - 8'd1;
					pick_model_phase();
				end
			end
			SCAN_VND_ENTRY: begin
				if (entry_pos < 2'd3) begin
					entry_held = entry_held | (24'(b) << (8 * entry_pos));
					entry_pos  = entry_pos + 2'd1;
				end else begin
					mid = {b, entry_held[23:16]};
					ok  = entry_held[15:0] == model_cfg.vendor_company_id;
					if (ok && mid == model_cfg.vendor_server_id) seen_vsrv = 1'b1;
					else if (ok && mid == model_cfg.vendor_client_id) seen_vcli = 1'b1;
					vnd_left = vnd_left - 8'd1;
					pick_model_phase();
				end
			end
			default: begin
				// two location bytes, then the sig count
				if (entry_pos == 0) begin
					scan_phase = SCAN_LOCATION;
					entry_pos  = 2'd1;
				end else begin
					scan_phase = SCAN_SIG_COUNT;
					entry_pos  = '0;
				end
			end
		endcase
		if (scan_count != 16'hFFFF) scan_count = scan_count + 16'd1;
		got = lst;
		res = '0;
		if (lst) begin
			if (scan_count >= mcms_pkg::HEADER_BYTES)
				res = '{1'b1, seen_srv, seen_cli, seen_vsrv, seen_vcli};
			scan_clear();
		end
	endtask

	// register write, one per cycle; caller lowers cfg_we afterwards
	task automatic write_reg(input logic [mcms_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			mcms_pkg::CFG_ONOFF_SERVER:  model_cfg.onoff_server_id   = val;
			mcms_pkg::CFG_ONOFF_CLIENT:  model_cfg.onoff_client_id   = val;
			mcms_pkg::CFG_VENDOR_CMPNY:  model_cfg.vendor_company_id = val;
			mcms_pkg::CFG_VENDOR_SERVER: model_cfg.vendor_server_id  = val;
			mcms_pkg::CFG_VENDOR_CLIENT: model_cfg.vendor_client_id  = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// one input transfer; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic lst,
			input logic fixed, input mcms_pkg::out_item_t want);
		bit                  got;
		mcms_pkg::out_item_t res;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, last_byte: lst};
		do @(posedge clk); while (!in_ready);
		items_sent++;
		scan_byte(b, lst, got, res);
		if (got) expected_flags_q.push_back(fixed ? want : res);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
	endtask

	// random frame: mostly well formed page 0 data, some noise and truncation
	task automatic build_frame(input bit noise_only);
		int          kind;
		int          n_elem;
		int          sc;
		int          vc;
		int          keep;
		logic [15:0] id;
		logic [15:0] cid;
		frame_bytes.delete();
		kind = $urandom_range(0, 99);
		if (noise_only || kind < 20) begin
			repeat ($urandom_range(1, noise_only ? 3 : 24)) frame_bytes.push_back(8'($urandom));
			return;
		end
		repeat (10) frame_bytes.push_back(8'($urandom));
		n_elem = $urandom_range(0, 3);
		repeat (n_elem) begin
			frame_bytes.push_back(8'($urandom));
			frame_bytes.push_back(8'($urandom));
			sc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
			vc = $urandom_range(0, 3);
			// a broken count runs past the end of the buffer
			if (kind >= 95) sc = $urandom_range(0, 255);
			if (kind >= 95 && $urandom_range(0, 1)) vc = $urandom_range(0, 255);
			frame_bytes.push_back(8'(sc));
			frame_bytes.push_back(8'(vc));
			if (sc > 8) sc = 8;
			if (vc > 4) vc = 4;
			repeat (sc) begin
				case ($urandom_range(0, 2))
					0:       id = model_cfg.onoff_server_id;
					1:       id = model_cfg.onoff_client_id;
					default: id = 16'($urandom);
				endcase
				frame_bytes.push_back(id[7:0]);
				frame_bytes.push_back(id[15:8]);
			end
			repeat (vc) begin
				cid = ($urandom_range(0, 9) < 7) ? model_cfg.vendor_company_id : 16'($urandom);
				case ($urandom_range(0, 2))
					0:       id = model_cfg.vendor_server_id;
					1:       id = model_cfg.vendor_client_id;
					default: id = 16'($urandom);
				endcase
				frame_bytes.push_back(cid[7:0]);
				frame_bytes.push_back(cid[15:8]);
				frame_bytes.push_back(id[7:0]);
				frame_bytes.push_back(id[15:8]);
			end
		end
		// cut short somewhere, often inside a model
		if (kind >= 95 || $urandom_range(0, 3) == 0) begin
			keep = $urandom_range(1, frame_bytes.size());
			while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
		end
	endtask

	// wait until every expected result has come, plus the output latency
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_flags_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		mcms_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_flags_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual %b", $time, out_data);
			end else begin
				want = expected_flags_q.pop_front();
				check_field("valid_data", want.valid_data, out_data.valid_data);
				check_field("has_onoff_server", want.has_onoff_server,
					out_data.has_onoff_server);
				check_field("has_onoff_client", want.has_onoff_client,
					out_data.has_onoff_client);
				check_field("has_vendor_server", want.has_vendor_server,
					out_data.has_vendor_server);
				check_field("has_vendor_client", want.has_vendor_client,
					out_data.has_vendor_client);
			end
		end
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// run limit
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// main sequence
	initial begin
		int setting;
		int item_mark;
		int result_mark;
		logic [15:0] v_srv;
		logic [15:0] v_vsrv;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		model_cfg = '{mcms_pkg::RST_ONOFF_SERVER, mcms_pkg::RST_ONOFF_CLIENT,
			mcms_pkg::RST_VENDOR_CMPNY, mcms_pkg::RST_VENDOR_SERVER,
			mcms_pkg::RST_VENDOR_CLIENT};
		scan_clear();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at the reset register values
		src_idle_pct  = 29;
		sink_idle_pct = 63;
		foreach (dir_rows[i])
			send_byte(dir_rows[i].data_byte, dir_rows[i].last_byte,
				dir_rows[i].fixed, dir_rows[i].want);
		settle();

		setting = 0;
		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct  = (mode == 0) ? 29 : (mode == 1) ? 63 : 0;
			sink_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 29 : 0;
			for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
				// register setting: zeros, ones, reset values, then random
				v_srv  = 16'($urandom);
				v_vsrv = 16'($urandom);
				case (setting)
					0: model_cfg = '0;
					1: model_cfg = '1;
					2: model_cfg = '{mcms_pkg::RST_ONOFF_SERVER, mcms_pkg::RST_ONOFF_CLIENT,
						mcms_pkg::RST_VENDOR_CMPNY, mcms_pkg::RST_VENDOR_SERVER,
						mcms_pkg::RST_VENDOR_CLIENT};
					default: begin
						model_cfg = '{v_srv, 16'($urandom), 16'($urandom), v_vsrv,
							16'($urandom)};
						// equal ids: only the server flag may be set
						if ($urandom_range(0, 3) == 0) model_cfg.onoff_client_id = v_srv;
						if ($urandom_range(0, 3) == 0) model_cfg.vendor_client_id = v_vsrv;
					end
				endcase
				write_reg(mcms_pkg::CFG_ONOFF_SERVER, model_cfg.onoff_server_id);
				write_reg(mcms_pkg::CFG_ONOFF_CLIENT, model_cfg.onoff_client_id);
				write_reg(mcms_pkg::CFG_VENDOR_CMPNY, model_cfg.vendor_company_id);
				write_reg(mcms_pkg::CFG_VENDOR_SERVER, model_cfg.vendor_server_id);
				write_reg(mcms_pkg::CFG_VENDOR_CLIENT, model_cfg.vendor_client_id);
				// an index past the last register is ignored
				write_reg(mcms_pkg::CFG_IDX_W'(mcms_pkg::CFG_VENDOR_CLIENT + 1 +
					$urandom_range(0, 2)), 16'($urandom));
				cfg_we <= 1'b0;
				@(negedge clk);
				setting++;

				// long receiver hold-off while short frames keep coming
				if (mode == 2 && s == 0) begin
					hold_req = 1'b1;
					repeat (6) begin
						build_frame(1'b1);
						send_frame();
					end
				end

				item_mark   = items_sent;
				result_mark = results_seen;
				while (items_sent - item_mark < ITEMS_PER_SETTING ||
						results_seen - result_mark < RESULTS_PER_SETTING) begin
					build_frame(1'b0);
					send_frame();
				end
				settle();
			end
		end

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ mesh_composition_model_scanner_unit.f @@
sv/mcms_pkg.sv
sv/mcms_cfg_regs.sv
sv/mcms_parser.sv
sv/mesh_composition_model_scanner_unit.sv
dv/mesh_composition_model_scanner_unit_test.sv
